### design/rgce_pkg.sv
// ----------------------------------------------------------------------------
// rgce_pkg
// types, codes and helpers shared by the reversible gate circuit evaluator
// ----------------------------------------------------------------------------
`default_nettype none

package rgce_pkg;

  localparam int WireCount    = 128;
  localparam int HalfWidth    = 64;
  localparam int WireIdxWidth = 7;
  localparam int GateWidth    = 3 * WireIdxWidth;
  localparam int StartWidth   = 8;
  localparam int CountWidth   = 8;
  localparam int ChunkBits    = 8;
  localparam int ChunkCount   = WireCount / ChunkBits;
  localparam int ChunkIdxWidth = $clog2(ChunkCount);
  localparam logic [StartWidth-1:0] StartReset = 8'd78;

  typedef enum logic [1:0] {
    OP_CLEAR   = 2'd0,
    OP_APPEND  = 2'd1,
    OP_REVERSE = 2'd2,
    OP_FORWARD = 2'd3
  } opcode_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_PRIME,
    ST_APPLY,
    ST_COUNT_INIT,
    ST_COUNT,
    ST_DONE
  } state_t;

  typedef struct packed {
    logic accept;
    logic fetch;
    logic apply;
    logic count_init;
    logic count_step;
    logic emit;
  } dp_cmd_t;

  typedef struct packed {
    logic total_zero;
    logic last;
  } dp_status_t;

  function automatic logic [3:0] popcount8(input logic [ChunkBits-1:0] v);
    logic [3:0] n;
    n = '0;
    for (int i = 0; i < ChunkBits; i++) begin
      n = n + {3'd0, v[i]};
    end
    return n;
  endfunction

endpackage

`default_nettype wire

### design/rgce_if.sv
// ----------------------------------------------------------------------------
// rgce channel interfaces
// valid/ready channels for items, results and the start bit register
// ----------------------------------------------------------------------------
`default_nettype none

interface rgce_item_if;
  logic        valid;
  logic        ready;
  logic [1:0]  opcode;
  logic [6:0]  target_wire;
  logic [6:0]  or_wire;
  logic [6:0]  not_wire;
  logic [63:0] word_high;
  logic [63:0] word_low;

  modport source (
    output valid, opcode, target_wire, or_wire, not_wire, word_high, word_low,
    input  ready
  );
  modport sink (
    input  valid, opcode, target_wire, or_wire, not_wire, word_high, word_low,
    output ready
  );
endinterface

interface rgce_result_if;
  logic        valid;
  logic        ready;
  logic [63:0] state_high;
  logic [63:0] state_low;
  logic [7:0]  mismatch_count;
  logic        program_full;

  modport source (
    output valid, state_high, state_low, mismatch_count, program_full,
    input  ready
  );
  modport sink (
    input  valid, state_high, state_low, mismatch_count, program_full,
    output ready
  );
endinterface

interface rgce_cfg_if;
  logic       valid;
  logic       ready;
  logic [7:0] score_start_bit;

  modport source (output valid, score_start_bit, input ready);
  modport sink (input valid, score_start_bit, output ready);
endinterface

`default_nettype wire

### design/rgce_ram.sv
// ----------------------------------------------------------------------------
// rgce_ram
// simple dual port ram, one write and one registered read per cycle
// ----------------------------------------------------------------------------
`default_nettype none

module rgce_ram #(
  parameter int WIDTH = 21,
  parameter int DEPTH = 1024,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk,
  input  wire logic             we,
  input  wire logic [AW-1:0]    waddr,
  input  wire logic [WIDTH-1:0] wdata,
  input  wire logic [AW-1:0]    raddr,
  output logic      [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

### design/rgce_ctrl.sv
// ----------------------------------------------------------------------------
// rgce_ctrl
// sequencer: item decode, gate walk, chunked popcount and result handoff
// ----------------------------------------------------------------------------
`default_nettype none

module rgce_ctrl import rgce_pkg::*; (
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       item_valid,
  input  wire logic [1:0] item_opcode,
  output logic            item_ready,
  output logic            result_valid,
  input  wire logic       result_ready,
  input  wire dp_status_t status,
  output dp_cmd_t         cmd,
  output state_t          state
);

  state_t                   state_next;
  logic [ChunkIdxWidth-1:0] chunk_idx;
  logic [ChunkIdxWidth-1:0] chunk_idx_next;
  logic                     result_valid_next;
  opcode_t                  op;

  assign op = opcode_t'(item_opcode);

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= ST_IDLE;
      chunk_idx    <= '0;
      result_valid <= 1'b0;
    end else begin
      state        <= state_next;
      chunk_idx    <= chunk_idx_next;
      result_valid <= result_valid_next;
    end
  end

  always_comb begin
    state_next     = state;
    chunk_idx_next = chunk_idx;
    item_ready     = 1'b0;
    cmd            = '0;
    case (state)
      ST_IDLE: begin
        item_ready = 1'b1;
        if (item_valid) begin
          cmd.accept = 1'b1;
          if (op inside {OP_CLEAR, OP_APPEND}) begin
            state_next = ST_DONE;
          end else if (status.total_zero) begin
            state_next = ST_COUNT_INIT;
          end else begin
            state_next = ST_PRIME;
          end
        end
      end
      ST_PRIME: begin
        cmd.fetch  = 1'b1;
        state_next = ST_APPLY;
      end
      ST_APPLY: begin
        cmd.apply = 1'b1;
        if (status.last) begin
          state_next = ST_COUNT_INIT;
        end else begin
          cmd.fetch = 1'b1;
        end
      end
      ST_COUNT_INIT: begin
        cmd.count_init = 1'b1;
        chunk_idx_next = '0;
        state_next     = ST_COUNT;
      end
      ST_COUNT: begin
        cmd.count_step = 1'b1;
        chunk_idx_next = chunk_idx + 1'b1;
        if (chunk_idx == ChunkIdxWidth'(ChunkCount - 1)) begin
          state_next = ST_DONE;
        end
      end
      ST_DONE: begin
        if (!result_valid || result_ready) begin
          cmd.emit   = 1'b1;
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_comb begin
    if (cmd.emit) begin
      result_valid_next = 1'b1;
    end else if (result_ready) begin
      result_valid_next = 1'b0;
    end else begin
      result_valid_next = result_valid;
    end
  end

endmodule

`default_nettype wire

### design/rgce_dp.sv
// ----------------------------------------------------------------------------
// rgce_dp
// gate store, wire register, gate apply, masked popcount and result register
// ----------------------------------------------------------------------------
`default_nettype none

module rgce_dp import rgce_pkg::*; #(
  parameter int MAX_GATES = 1024,
  localparam int AW = (MAX_GATES > 1) ? $clog2(MAX_GATES) : 1,
  localparam int CW = $clog2(MAX_GATES + 1)
) (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire dp_cmd_t               cmd,
  output dp_status_t                 status,
  input  wire logic [1:0]            item_opcode,
  input  wire logic [6:0]            item_target_wire,
  input  wire logic [6:0]            item_or_wire,
  input  wire logic [6:0]            item_not_wire,
  input  wire logic [HalfWidth-1:0]  item_word_high,
  input  wire logic [HalfWidth-1:0]  item_word_low,
  input  wire logic                  cfg_we,
  input  wire logic [StartWidth-1:0] cfg_start,
  output logic      [HalfWidth-1:0]  res_state_high,
  output logic      [HalfWidth-1:0]  res_state_low,
  output logic      [CountWidth-1:0] res_mismatch_count,
  output logic                       res_program_full
);

  opcode_t               op;
  logic [CW-1:0]         gate_total;
  logic [CW-1:0]         remaining;
  logic [AW-1:0]         rd_addr;
  logic [GateWidth-1:0]  gate;
  logic [WireCount-1:0]  wires;
  logic [WireCount-1:0]  wires_next;
  logic [WireCount-1:0]  count_bits;
  logic [WireCount-1:0]  mask;
  logic [CountWidth-1:0] count;
  logic [StartWidth-1:0] score_start_bit;
  logic                  is_eval;
  logic                  reverse;
  logic                  full_flag;
  logic                  store_full;
  logic                  store_we;
  logic                  flip;
  logic [WireIdxWidth-1:0] t_idx;
  logic [WireIdxWidth-1:0] a_idx;
  logic [WireIdxWidth-1:0] b_idx;

  assign op         = opcode_t'(item_opcode);
  assign store_full = (gate_total == CW'(MAX_GATES));
  assign store_we   = cmd.accept && (op == OP_APPEND) && !store_full;

  rgce_ram #(
    .WIDTH (GateWidth),
    .DEPTH (MAX_GATES)
  ) u_gate_store (
    .clk   (clk),
    .we    (store_we),
    .waddr (gate_total[AW-1:0]),
    .wdata ({item_target_wire, item_or_wire, item_not_wire}),
    .raddr (rd_addr),
    .rdata (gate)
  );

  assign t_idx = gate[GateWidth-1 -: WireIdxWidth];
  assign a_idx = gate[2*WireIdxWidth-1 -: WireIdxWidth];
  assign b_idx = gate[WireIdxWidth-1:0];
  assign flip  = wires[a_idx] | ~wires[b_idx];

  always_comb begin
    wires_next = wires;
    wires_next[t_idx] = wires[t_idx] ^ flip;
  end

  always_comb begin
    for (int i = 0; i < WireCount; i++) begin
      mask[i] = (StartWidth'(i) >= score_start_bit);
    end
  end

  assign status.total_zero = (gate_total == '0);
  assign status.last       = (remaining == '0);

  // control-side registers
  always_ff @(posedge clk) begin
    if (rst) begin
      gate_total      <= '0;
      score_start_bit <= StartReset;
    end else begin
      if (cfg_we) begin
        score_start_bit <= cfg_start;
      end
      if (cmd.accept && op == OP_CLEAR) begin
        gate_total <= '0;
      end else if (store_we) begin
        gate_total <= gate_total + 1'b1;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      is_eval   <= (op == OP_REVERSE) || (op == OP_FORWARD);
      reverse   <= (op == OP_REVERSE);
      full_flag <= (op == OP_APPEND) && store_full;
      remaining <= gate_total;
      if (op == OP_REVERSE) begin
        rd_addr <= AW'(gate_total - 1'b1);
      end else begin
        rd_addr <= '0;
      end
      if ((op == OP_REVERSE) || (op == OP_FORWARD)) begin
        wires <= {item_word_high, item_word_low};
      end
    end else begin
      if (cmd.fetch) begin
        rd_addr   <= reverse ? (rd_addr - 1'b1) : (rd_addr + 1'b1);
        remaining <= remaining - 1'b1;
      end
      if (cmd.apply) begin
        wires <= wires_next;
      end
    end

    if (cmd.count_init) begin
      count_bits <= wires & mask;
      count      <= '0;
    end else if (cmd.count_step) begin
      count_bits <= count_bits >> ChunkBits;
      count      <= count + CountWidth'(popcount8(count_bits[ChunkBits-1:0]));
    end

    if (cmd.emit) begin
      res_state_high     <= is_eval ? wires[WireCount-1:HalfWidth] : '0;
      res_state_low      <= is_eval ? wires[HalfWidth-1:0] : '0;
      res_mismatch_count <= is_eval ? count : '0;
      res_program_full   <= full_flag;
    end
  end

endmodule

`default_nettype wire

### design/reversible_gate_circuit_eval.sv
// ----------------------------------------------------------------------------
// reversible_gate_circuit_eval
// program store and evaluator for reversible gates over 128 one-bit wires
//
// item channel: clear, append one gate, or evaluate a 128-bit state forward
//   (first gate to last) or in reverse (last gate to first)
// result channel: one result per item with the state, the count of set
//   wires at or above score_start_bit and the dropped-append flag
// cfg channel: always ready, writes score_start_bit
// sequence after an item is accepted: clear and append go straight to the
//   handoff; an evaluation over n > 0 stored gates primes the registered
//   read of the gate store, applies the gates one by one, sets up the
//   count, runs a popcount over the 128 wires at 8 wires a cycle and then
//   hands off; an evaluation of an empty program skips the prime and gate walk
// one item is in flight at a time; the next item is taken in the cycle
//   after the result is loaded
// a finished result waits in the output register while the next item is
//   taken; that item's result stalls until the receiver takes the old one
// reset clears the program and sets score_start_bit to 78; no clearing pass
// ----------------------------------------------------------------------------
`default_nettype none

module reversible_gate_circuit_eval import rgce_pkg::*; #(
  parameter int MAX_GATES = 1024
) (
  input  wire logic   clk,
  input  wire logic   rst,
  rgce_item_if.sink   item,
  rgce_result_if.source result,
  rgce_cfg_if.sink    cfg
);

  dp_cmd_t    cmd;
  dp_status_t status;
  state_t     state;

  assign cfg.ready = 1'b1;

  rgce_ctrl u_ctrl (
    .clk          (clk),
    .rst          (rst),
    .item_valid   (item.valid),
    .item_opcode  (item.opcode),
    .item_ready   (item.ready),
    .result_valid (result.valid),
    .result_ready (result.ready),
    .status       (status),
    .cmd          (cmd),
    .state        (state)
  );

  rgce_dp #(
    .MAX_GATES (MAX_GATES)
  ) u_dp (
    .clk                (clk),
    .rst                (rst),
    .cmd                (cmd),
    .status             (status),
    .item_opcode        (item.opcode),
    .item_target_wire   (item.target_wire),
    .item_or_wire       (item.or_wire),
    .item_not_wire      (item.not_wire),
    .item_word_high     (item.word_high),
    .item_word_low      (item.word_low),
    .cfg_we             (cfg.valid && cfg.ready),
    .cfg_start          (cfg.score_start_bit),
    .res_state_high     (result.state_high),
    .res_state_low      (result.state_low),
    .res_mismatch_count (result.mismatch_count),
    .res_program_full   (result.program_full)
  );

  a_count_range: assert property (@(posedge clk) disable iff (rst)
    result.valid |-> (result.mismatch_count <= 8'd128))
    else $error("mismatch count above wire count");

  a_full_zero: assert property (@(posedge clk) disable iff (rst)
    (result.valid && result.program_full) |->
      (result.state_high == '0 && result.state_low == '0 &&
       result.mismatch_count == '0))
    else $error("dropped append reports nonzero state");

  a_accept_leaves_idle: assert property (@(posedge clk) disable iff (rst)
    (item.valid && item.ready) |=> (state != ST_IDLE))
    else $error("transfer did not start work");

  a_apply_flow: assert property (@(posedge clk) disable iff (rst)
    (state == ST_APPLY) |=> (state == ST_APPLY || state == ST_COUNT_INIT))
    else $error("gate walk left early");

endmodule

`default_nettype wire
